/* rtl/smallest_prime_factor_sieve_defines.svh */
// assertion macros for the smallest prime factor sieve
`ifndef SMALLEST_PRIME_FACTOR_SIEVE_DEFINES_SVH
`define SMALLEST_PRIME_FACTOR_SIEVE_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define SPFS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off while i_rst_n is low
`define SPFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/spfs_pkg.sv */
// shared constants and types of the smallest prime factor sieve
package spfs_pkg;

    localparam int NUM_W     = 16;     // number and factor width
    localparam int LIM_W     = 17;     // limit width, holds 65536
    localparam int PRIME_W   = 9;      // sieving prime, up to 257
    localparam int TBL_CAP   = 65536;  // largest table a 16-bit factor allows
    localparam int DEF_MAX_N = 65536;

    localparam logic [LIM_W-1:0] LIMIT_RST = LIM_W'(65536);

    localparam logic       CMD_BUILD  = 1'b0;
    localparam logic       CMD_LOOKUP = 1'b1;

    typedef struct packed {
        logic [NUM_W-1:0] factor;
        logic             valid_res;
    } t_res;

    // value a build writes before the odd primes strike their multiples
    function automatic logic [NUM_W-1:0] fill_value(input logic [LIM_W-1:0] idx);
        logic [NUM_W-1:0] v;
        if (idx == LIM_W'(1)) begin
            v = NUM_W'(1);
        end else if (!idx[0]) begin
            v = NUM_W'(2);
        end else begin
            v = idx[NUM_W-1:0];
        end
        return v;
    endfunction

endpackage

/* rtl/smallest_prime_factor_sieve.sv */
// smallest prime factor table: build on command, then serve lookups
//
//  channel   dir  handshake                 payload
//  request   in   i_in_valid / o_in_ready   i_cmd, i_number
//  result    out  o_out_valid / i_out_ready o_factor, o_valid_res
//  config    in   i_cfg_we                  i_cfg_limit
//
// lookups: one per cycle while idle with queue room, result via memory read and output queue
// build: fill of entries 1 .. n-1, a primality read and check for each odd i with i*i < n, a
//   strike of each odd multiple of a prime i from i*i, then a last read and a finish state
// reset: synchronous; afterwards a clearing pass writes zero to all min(MAX_N, 65536) table
//   entries, with no request taken (config writes still land)
// a stalled result side fills the two-entry output queue and then holds o_in_ready low
`include "smallest_prime_factor_sieve_defines.svh"

module smallest_prime_factor_sieve #(
    parameter int MAX_N = spfs_pkg::DEF_MAX_N
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_cmd,
    input  logic [spfs_pkg::NUM_W-1:0]  i_number,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [spfs_pkg::NUM_W-1:0]  o_factor,
    output logic                        o_valid_res,
    input  logic                        i_cfg_we,
    input  logic [spfs_pkg::LIM_W-1:0]  i_cfg_limit
);
    import spfs_pkg::*;

    // table depth: entries past 65535 could never be built or looked up
    localparam int DEPTH = (MAX_N > TBL_CAP) ? TBL_CAP : MAX_N;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [LIM_W-1:0] DEPTH_L = LIM_W'(DEPTH);
    localparam logic [AW-1:0]    LAST_A  = AW'(DEPTH - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,      // zero the table after reset
        ST_IDLE,       // take requests, lookups stream through
        ST_FILL,       // write 1, 2 or the index itself into entries 1 .. n-1
        ST_PRIME_RD,   // read entry i, or finish once i*i >= n
        ST_PRIME_CHK,  // entry i still equal to i means i is prime
        ST_STRIKE,     // read odd multiples of i, write i where unmarked
        ST_FINISH      // record built limit, queue the build result
    } t_state;

    // table memory, one write and one read port, registered read data
    logic [NUM_W-1:0] mem [DEPTH];
    logic [NUM_W-1:0] r_rdata;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [NUM_W-1:0] mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;

    // control and build state
    t_state             r_state;
    logic [AW-1:0]      r_clr_addr;
    logic [LIM_W-1:0]   r_limit;
    logic [LIM_W-1:0]   r_built;
    logic [LIM_W-1:0]   r_n;
    logic [LIM_W-1:0]   r_idx;
    logic [PRIME_W-1:0] r_prime;
    logic [LIM_W-1:0]   r_j;
    logic               r_pend_v;    // strike read in flight
    logic [AW-1:0]      r_pend_j;

    // lookup in flight, its flags travel beside the memory read
    logic               r_lk_pend;
    logic               r_lk_valid;
    logic               r_lk_inrng;

    // two-entry result queue
    t_res               r_q [2];
    logic               r_wp;
    logic               r_rp;
    logic [1:0]         r_cnt;

    logic [2*PRIME_W-1:0] sq;
    logic [LIM_W-1:0]     step;
    logic [LIM_W-1:0]     eff_limit;
    logic                 sq_done;
    logic                 j_done;
    logic                 pop;
    logic                 push_v;
    t_res                 push_d;
    logic [2:0]           occ;
    logic                 room;
    logic                 in_acc;
    logic                 lk_acc;
    logic                 bd_acc;
    logic                 strike_hit;

    // --- datapath helpers
    assign sq        = r_prime * r_prime;
    assign sq_done   = sq >= {1'b0, r_n};
    assign step      = {{(LIM_W - PRIME_W - 1){1'b0}}, r_prime, 1'b0};  // skip even multiples
    assign j_done    = r_j >= r_n;
    assign eff_limit = (r_limit > DEPTH_L) ? DEPTH_L : r_limit;

    // --- request side: queue room counts the lookup still in the memory
    assign pop        = o_out_valid && i_out_ready;
    assign occ        = {1'b0, r_cnt} + {2'b00, r_lk_pend};
    assign room       = occ < (3'd2 + {2'b00, pop});
    assign o_in_ready = (r_state == ST_IDLE) && room;
    assign in_acc     = i_in_valid && o_in_ready;
    assign lk_acc     = in_acc && (i_cmd == CMD_LOOKUP);
    assign bd_acc     = in_acc && (i_cmd == CMD_BUILD);

    // strike: overwrite only entries that still hold their own index
    assign strike_hit = r_pend_v && (r_rdata == NUM_W'(r_pend_j));

    // --- memory port muxes
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_pend_j;
        mem_wdata = NUM_W'(r_prime);
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else if (r_state == ST_FILL) begin
            mem_we    = 1'b1;
            mem_waddr = r_idx[AW-1:0];
            mem_wdata = fill_value(r_idx);
        end else if (strike_hit) begin
            mem_we    = 1'b1;
        end
    end

    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = i_number[AW-1:0];
        unique case (r_state)
            ST_IDLE: begin
                mem_re = lk_acc;
            end
            ST_PRIME_RD: begin
                mem_re    = !sq_done;
                mem_raddr = AW'(r_prime);
            end
            ST_STRIKE: begin
                mem_re    = !j_done;
                mem_raddr = r_j[AW-1:0];
            end
            default: begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    // --- result queue push: lookup data in the cycle after the read, or build done
    always_comb begin
        push_v = 1'b0;
        push_d = '{factor: '0, valid_res: 1'b1};
        if (r_lk_pend) begin
            push_v = 1'b1;
            push_d = '{factor: r_lk_inrng ? r_rdata : '0, valid_res: r_lk_valid};
        end else if (r_state == ST_FINISH) begin
            push_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push_v) begin
                r_q[r_wp] <= push_d;
                r_wp      <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push_v} - {1'b0, pop};
        end
    end

    assign o_out_valid = r_cnt != 2'd0;
    assign o_factor    = r_q[r_rp].factor;
    assign o_valid_res = r_q[r_rp].valid_res;

    // --- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_limit    <= LIMIT_RST;
            r_built    <= '0;
            r_pend_v   <= 1'b0;
            r_lk_pend  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_limit;
            end
            r_lk_pend <= lk_acc;
            r_pend_v  <= (r_state == ST_STRIKE) && !j_done;
            if (lk_acc) begin
                r_lk_valid <= (i_number != '0) && ({1'b0, i_number} < r_built);
                r_lk_inrng <= {1'b0, i_number} < DEPTH_L;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == LAST_A) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (bd_acc) begin
                        r_n   <= eff_limit;
                        r_idx <= LIM_W'(1);
                        // a limit below two builds nothing
                        r_state <= (eff_limit < LIM_W'(2)) ? ST_FINISH : ST_FILL;
                    end
                end
                ST_FILL: begin
                    r_idx <= r_idx + LIM_W'(1);
                    if (r_idx == r_n - LIM_W'(1)) begin
                        r_prime <= PRIME_W'(3);
                        r_state <= ST_PRIME_RD;
                    end
                end
                ST_PRIME_RD: begin
                    r_state <= sq_done ? ST_FINISH : ST_PRIME_CHK;
                end
                ST_PRIME_CHK: begin
                    if (r_rdata == NUM_W'(r_prime)) begin
                        r_j     <= LIM_W'(sq);
                        r_state <= ST_STRIKE;
                    end else begin
                        r_prime <= r_prime + PRIME_W'(2);
                        r_state <= ST_PRIME_RD;
                    end
                end
                ST_STRIKE: begin
                    if (j_done) begin
                        // the last pending write lands in this cycle, ahead of the
                        // next primality read
                        r_prime <= r_prime + PRIME_W'(2);
                        r_state <= ST_PRIME_RD;
                    end else begin
                        r_pend_j <= r_j[AW-1:0];
                        r_j      <= r_j + step;
                    end
                end
                ST_FINISH: begin
                    r_built <= r_n;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // --- checks
    `SPFS_ASSERT_NOW(a_queue_no_overflow, push_v, (r_cnt != 2'd2) || pop, "result queue overflow")
    `SPFS_ASSERT_NOW(a_no_write_idle, r_state == ST_IDLE, !mem_we, "table written while serving lookups")
    `SPFS_ASSERT_NOW(a_factor_le_addr, mem_we, mem_wdata <= NUM_W'(mem_waddr), "stored factor exceeds its number")
    `SPFS_ASSERT_NOW(a_no_push_clash, r_lk_pend, r_state != ST_FINISH, "lookup and build result collide")
    `SPFS_ASSERT_NEXT(a_build_result, r_state == ST_FINISH, o_out_valid, "build result not presented")

endmodule
